// ===== sv/flow_session_table_defines.svh =====
// Assertion helpers for the flow session table.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef FLOW_SESSION_TABLE_DEFINES_SVH
`define FLOW_SESSION_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define FST_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("flow table check failed");
`define FST_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("flow table forbidden condition");
`else
`define FST_ASSERT(label, prop)
`define FST_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== sv/fst_pkg.sv =====
`timescale 1ns / 1ps
package fst_pkg;

  localparam int unsigned DefTableDepth  = 1024;
  localparam logic [31:0] DefIdleTimeout = 32'd60;
  localparam logic [31:0] HashMul        = 32'h045d9f3b;
  localparam int unsigned MaxIdxW        = 16;
  localparam logic [31:0] PktMax         = 32'hFFFF_FFFF;
  localparam logic [47:0] ByteMax        = 48'hFFFF_FFFF_FFFF;

  typedef enum logic {
    REQ_PACKET = 1'b0,
    REQ_EXPIRE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_MOD,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PKT,
    BK_SWEEP
  } back_state_e;

  typedef struct packed {
    req_type_e            kind;
    logic [31:0]          src_addr;
    logic [31:0]          dst_addr;
    logic [15:0]          sport;
    logic [15:0]          dport;
    logic [7:0]           protocol;
    logic [15:0]          length;
    logic [31:0]          now;
    logic [MaxIdxW-1:0]   slot;
  } fst_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  protocol;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [31:0] seen_time;
  } fst_entry_t;

  typedef struct packed {
    logic        hit;
    logic        new_flow;
    logic        evicted;
    logic [9:0]  slot_index;
    logic [31:0] flow_packets;
    logic [47:0] flow_bytes;
    logic [10:0] active_flows;
    logic [10:0] expired_flows;
  } fst_result_t;

  // First mixing stage: fold the five-tuple and xor-shift.
  function automatic logic [31:0] mix_pre(input logic [31:0] sa, input logic [31:0] da,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [7:0] pr);
    logic [31:0] h;
    h = sa ^ da ^ {sp, dp} ^ {24'd0, pr};
    return h ^ (h >> 16);
  endfunction

endpackage

// ===== sv/fst_queue.sv =====
`timescale 1ns / 1ps
module fst_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fst_pkg::fst_req_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output fst_pkg::fst_req_t pop_data_o,
  output logic             empty_o
);

  fst_pkg::fst_req_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);

endmodule

// ===== sv/fst_front.sv =====
`timescale 1ns / 1ps
module fst_front #(
  parameter int unsigned TableDepth = fst_pkg::DefTableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              req_type_i,
  input  logic [31:0]       src_addr_i,
  input  logic [31:0]       dst_addr_i,
  input  logic [15:0]       src_port_num_i,
  input  logic [15:0]       dst_port_num_i,
  input  logic [7:0]        protocol_i,
  input  logic [15:0]       packet_length_i,
  input  logic [31:0]       now_seconds_i,
  output logic              busy_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output fst_pkg::fst_req_t q_data_o
);

  // quotient by the depth: (h * m) >> (32 + IdxW), m = 2^32 + RecipLow
  localparam int unsigned IdxW      = $clog2(TableDepth);
  localparam int unsigned Shift     = 32 + IdxW;
  localparam logic [63:0] RecipFull = ((64'd1 << Shift) / 64'(TableDepth)) + 64'd1;
  localparam logic [31:0] RecipLow  = 32'(RecipFull);
  localparam logic [16:0] DepthV    = 17'(TableDepth);

  fst_pkg::front_state_e state_q, state_d;
  fst_pkg::fst_req_t     req_q;
  logic [31:0]           h_q, prod;
  logic [63:0]           rprod;
  logic [64:0]           qsum, qshift;
  logic [31:0]           quo_d, quo_q, rem_full;
  logic [48:0]           qd;

  assign prod = h_q * fst_pkg::HashMul;

  assign rprod  = {32'd0, h_q} * {32'd0, RecipLow};
  assign qsum   = {1'b0, h_q, 32'd0} + {1'b0, rprod};
  assign qshift = qsum >> Shift;
  assign quo_d  = qshift[31:0];

  // remainder from the registered quotient
  assign qd       = {17'd0, quo_q} * {32'd0, DepthV};
  assign rem_full = h_q - qd[31:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      fst_pkg::FR_IDLE: begin
        if (start_i) begin
          state_d = (fst_pkg::req_type_e'(req_type_i) == fst_pkg::REQ_EXPIRE) ?
                    fst_pkg::FR_PUSH : fst_pkg::FR_MUL;
        end
      end
      fst_pkg::FR_MUL:  state_d = fst_pkg::FR_MOD;
      fst_pkg::FR_MOD:  state_d = fst_pkg::FR_PUSH;
      fst_pkg::FR_PUSH: if (!q_full_i) state_d = fst_pkg::FR_IDLE;
      default:          state_d = fst_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    busy_o        = (state_q != fst_pkg::FR_IDLE);
    q_push_o      = (state_q == fst_pkg::FR_PUSH) && !q_full_i;
    q_data_o      = req_q;
    q_data_o.slot = rem_full[fst_pkg::MaxIdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fst_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fst_pkg::FR_IDLE: begin
        req_q.kind     <= fst_pkg::req_type_e'(req_type_i);
        req_q.src_addr <= src_addr_i;
        req_q.dst_addr <= dst_addr_i;
        req_q.sport    <= src_port_num_i;
        req_q.dport    <= dst_port_num_i;
        req_q.protocol <= protocol_i;
        req_q.length   <= packet_length_i;
        req_q.now      <= now_seconds_i;
        req_q.slot     <= '0;
        h_q   <= fst_pkg::mix_pre(src_addr_i, dst_addr_i, src_port_num_i,
                                  dst_port_num_i, protocol_i);
      end
      fst_pkg::FR_MUL: h_q <= prod ^ (prod >> 16);
      fst_pkg::FR_MOD: quo_q <= quo_d;
      default: ;
    endcase
  end

endmodule

// ===== sv/fst_back.sv =====
`timescale 1ns / 1ps
`include "flow_session_table_defines.svh"
module fst_back #(
  parameter int unsigned TableDepth = fst_pkg::DefTableDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  fst_pkg::fst_req_t    q_data_i,
  output logic                 q_pop_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  output logic                 clearing_o,
  output logic                 done_o,
  output fst_pkg::fst_result_t result_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  fst_pkg::fst_entry_t mem_q [TableDepth];
  fst_pkg::fst_entry_t rdata_q, wdata;
  logic                mem_we, rd_en;
  logic [IdxW-1:0]     wr_addr, rd_addr, slot;

  fst_pkg::back_state_e state_q, state_d;
  fst_pkg::fst_req_t    req_q, req_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      vt_q, vt_d, exp_q, exp_d;
  logic [31:0]          timeout_q;
  logic                 done_d;
  fst_pkg::fst_result_t res_q, res_d;

  logic        hit, fwd, rev, expire;
  logic [31:0] base_pk, new_pk, slot_ext, vt_ext, exp_ext;
  logic [47:0] base_by, new_by;
  logic [48:0] by_sum;

  assign slot = req_q.slot[IdxW-1:0];

  always_comb begin
    fwd = (rdata_q.src_addr == req_q.src_addr) && (rdata_q.dst_addr == req_q.dst_addr) &&
          (rdata_q.ports == {req_q.sport, req_q.dport});
    rev = (rdata_q.src_addr == req_q.dst_addr) && (rdata_q.dst_addr == req_q.src_addr) &&
          (rdata_q.ports == {req_q.dport, req_q.sport});
    hit = rdata_q.valid && (rdata_q.protocol == req_q.protocol) && (fwd || rev);
    base_pk = hit ? rdata_q.packets : 32'd0;
    base_by = hit ? rdata_q.bytes : 48'd0;
    new_pk  = (base_pk == fst_pkg::PktMax) ? fst_pkg::PktMax : base_pk + 32'd1;
    by_sum  = {1'b0, base_by} + {33'd0, req_q.length};
    new_by  = by_sum[48] ? fst_pkg::ByteMax : by_sum[47:0];
    // idle time is taken modulo 2^32
    expire  = rdata_q.valid && ((req_q.now - rdata_q.seen_time) > timeout_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fst_pkg::BK_CLEAR: if (idx_q == LastIdx) state_d = fst_pkg::BK_IDLE;
      fst_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_data_i.kind == fst_pkg::REQ_EXPIRE) ? fst_pkg::BK_SWEEP
                                                           : fst_pkg::BK_PKT;
        end
      end
      fst_pkg::BK_PKT:   state_d = fst_pkg::BK_IDLE;
      fst_pkg::BK_SWEEP: if (idx_q == LastIdx) state_d = fst_pkg::BK_IDLE;
      default:           state_d = fst_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wdata   = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    q_pop_o = 1'b0;
    req_d   = req_q;
    idx_d   = idx_q;
    vt_d    = vt_q;
    exp_d   = exp_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      fst_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + IdxW'(1);
      end
      fst_pkg::BK_IDLE: begin
        q_pop_o = !q_empty_i;
        rd_en   = !q_empty_i;
        if (q_data_i.kind == fst_pkg::REQ_PACKET) rd_addr = q_data_i.slot[IdxW-1:0];
        req_d = q_data_i;
        idx_d = '0;
        exp_d = '0;
      end
      fst_pkg::BK_PKT: begin
        mem_we  = 1'b1;
        wr_addr = slot;
        wdata   = '{valid: 1'b1, src_addr: req_q.src_addr, dst_addr: req_q.dst_addr,
                    ports: {req_q.sport, req_q.dport}, protocol: req_q.protocol,
                    packets: new_pk, bytes: new_by, seen_time: req_q.now};
        if (!hit && !rdata_q.valid) vt_d = vt_q + CntW'(1);
        done_d             = 1'b1;
        res_d              = '0;
        res_d.hit          = hit;
        res_d.new_flow     = !hit;
        res_d.evicted      = !hit && rdata_q.valid;
        res_d.slot_index   = slot_ext[9:0];
        res_d.flow_packets = new_pk;
        res_d.flow_bytes   = new_by;
        res_d.active_flows = vt_ext[10:0];
      end
      fst_pkg::BK_SWEEP: begin
        // read runs one entry ahead of the compare and write-back
        if (expire) begin
          mem_we = 1'b1;
          vt_d   = vt_q - CntW'(1);
          exp_d  = exp_q + CntW'(1);
        end
        rd_en   = (idx_q != LastIdx);
        rd_addr = idx_q + IdxW'(1);
        idx_d   = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          done_d              = 1'b1;
          res_d               = '0;
          res_d.active_flows  = vt_ext[10:0];
          res_d.expired_flows = exp_ext[10:0];
        end
      end
      default: ;
    endcase
  end

  assign slot_ext = 32'(slot);
  assign vt_ext   = 32'(vt_d);
  assign exp_ext  = 32'(exp_d);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wdata;
    if (rd_en) rdata_q <= mem_q[rd_addr];
    req_q <= req_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fst_pkg::BK_CLEAR;
      idx_q     <= '0;
      vt_q      <= '0;
      exp_q     <= '0;
      done_o    <= 1'b0;
      timeout_q <= fst_pkg::DefIdleTimeout;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      vt_q    <= vt_d;
      exp_q   <= exp_d;
      done_o  <= done_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
    end
  end

  assign clearing_o = (state_q == fst_pkg::BK_CLEAR);
  assign result_o   = res_q;

  `FST_ASSERT_NEVER(a_hit_and_new, done_o && res_q.hit && res_q.new_flow)
  `FST_ASSERT_NEVER(a_evict_needs_new, done_o && res_q.evicted && !res_q.new_flow)
  `FST_ASSERT_NEVER(a_count_bound, vt_q > CntW'(TableDepth))
  `FST_ASSERT(a_no_result_after_clear, $past(clearing_o) |-> !done_o)

endmodule

// ===== sv/flow_session_table.sv =====
`timescale 1ns / 1ps
// Direct-mapped flow table with a hashed five-tuple index.
// Input: an item is taken when start is high and busy is low. req_type_i
//   selects a packet lookup (0) or an expire sweep (1).
// Output: done_o pulses for one cycle with the result fields; the receiver
//   cannot stall, so every result is taken in that cycle.
// Config: idle_timeout_we_i writes idle_timeout_i (reset value 60 s); write
//   only while the table is idle.
// Path: a packet request passes the front-end multiply, quotient and
//   handoff steps (remainder formed at the handoff); the back end then
//   needs a read and an update on the single table memory.
// Occupancy: the front end is busy through the multiply, quotient and
//   handoff steps after a packet accept, so it takes no new packet
//   transaction until its handoff is done.
// Sweep: an expire item walks all TableDepth slots, one per cycle; later
//   items wait in the queue and then hold busy high.
// Reset: the table memory is cleared in one pass over all TableDepth
//   slots; busy is held high during it.
module flow_session_table #(
  parameter int unsigned TableDepth = fst_pkg::DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_num_i,
  input  logic [15:0] dst_port_num_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] now_seconds_i,
  input  logic        idle_timeout_we_i,
  input  logic [31:0] idle_timeout_i,
  output logic        done_o,
  output logic        hit_o,
  output logic        new_flow_o,
  output logic        evicted_o,
  output logic [9:0]  slot_index_o,
  output logic [31:0] flow_packets_o,
  output logic [47:0] flow_bytes_o,
  output logic [10:0] active_flows_o,
  output logic [10:0] expired_flows_o
);

  fst_pkg::fst_req_t    push_data, pop_data;
  fst_pkg::fst_result_t result;
  logic front_busy, clearing, q_full, q_empty, q_push, q_pop;

  // no new transaction while the table is still being cleared
  assign busy = front_busy | clearing;

  fst_front #(.TableDepth(TableDepth)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start & ~clearing),
    .req_type_i      (req_type_i),
    .src_addr_i      (src_addr_i),
    .dst_addr_i      (dst_addr_i),
    .src_port_num_i  (src_port_num_i),
    .dst_port_num_i  (dst_port_num_i),
    .protocol_i      (protocol_i),
    .packet_length_i (packet_length_i),
    .now_seconds_i   (now_seconds_i),
    .busy_o          (front_busy),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (push_data)
  );

  // short queue decouples hashing from table access
  fst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  fst_back #(.TableDepth(TableDepth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .q_pop_o     (q_pop),
    .cfg_we_i    (idle_timeout_we_i),
    .cfg_wdata_i (idle_timeout_i),
    .clearing_o  (clearing),
    .done_o      (done_o),
    .result_o    (result)
  );

  assign hit_o           = result.hit;
  assign new_flow_o      = result.new_flow;
  assign evicted_o       = result.evicted;
  assign slot_index_o    = result.slot_index;
  assign flow_packets_o  = result.flow_packets;
  assign flow_bytes_o    = result.flow_bytes;
  assign active_flows_o  = result.active_flows;
  assign expired_flows_o = result.expired_flows;

endmodule
